// ----- src/e2q_pkg.sv -----
// shared types, constants and tables for the euler to quaternion block
// no dependencies; used by every module in src
`default_nettype none
package e2q_pkg;
	localparam int ANGLE_W = 16;
	localparam int COMP_W  = 16;
	localparam int STEPS   = 28;
	localparam int XY_W    = 34;
	localparam int Z_W     = 35;
	localparam int FRAC    = 30;
	localparam logic signed [XY_W-1:0] GAIN = 34'sd652032874;

	localparam logic [2:0] ORD_XYZ = 3'd0;
	localparam logic [2:0] ORD_YXZ = 3'd1;
	localparam logic [2:0] ORD_ZXY = 3'd2;
	localparam logic [2:0] ORD_ZYX = 3'd3;
	localparam logic [2:0] ORD_YZX = 3'd4;
	localparam logic [2:0] ORD_XZY = 3'd5;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_x;
		logic signed [ANGLE_W-1:0] angle_y;
		logic signed [ANGLE_W-1:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] quat_x;
		logic signed [COMP_W-1:0] quat_y;
		logic signed [COMP_W-1:0] quat_z;
		logic signed [COMP_W-1:0] quat_w;
	} quat_t;

	// atan(2^-i), 2^32 per full turn
	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] t;
		unique case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			default: t = 32'h00000005;
		endcase
		return t;
	endfunction

	// bit 3: x minus, bit 2: y minus, bit 1: z minus, bit 0: w minus
	function automatic logic [3:0] order_signs(input logic [2:0] ord);
		logic [3:0] s;
		unique case (ord)
			ORD_XYZ: s = 4'h5;
			ORD_YXZ: s = 4'h6;
			ORD_ZXY: s = 4'h9;
			ORD_ZYX: s = 4'hA;
			ORD_YZX: s = 4'h3;
			ORD_XZY: s = 4'hC;
			default: s = 4'h0;
		endcase
		return s;
	endfunction
endpackage
`default_nettype wire

// ----- src/e2q_cordic_cell.sv -----
// one rotation-mode cordic iteration with its output register
// depends on e2q_pkg for widths and the arctangent table
`default_nettype none
module e2q_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [e2q_pkg::XY_W-1:0]    x_in,
	input  wire logic signed [e2q_pkg::XY_W-1:0]    y_in,
	input  wire logic signed [e2q_pkg::Z_W-1:0]     z_in,
	output logic signed [e2q_pkg::XY_W-1:0]         x_q,
	output logic signed [e2q_pkg::XY_W-1:0]         y_q,
	output logic signed [e2q_pkg::Z_W-1:0]          z_q
);
	logic signed [e2q_pkg::XY_W-1:0] dx, dy;
	logic signed [e2q_pkg::Z_W-1:0]  dz;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	// twice the table entry, half angle units
	assign dz = signed'({2'b00, e2q_pkg::atan_step(STEP), 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[e2q_pkg::Z_W-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - dz;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + dz;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/e2q_combine.sv -----
// three-stage product, sum, round and saturate of the half-angle sines and cosines
// depends on e2q_pkg for widths, order codes and the sign table
`default_nettype none
module e2q_combine (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [e2q_pkg::XY_W-1:0]  c1, s1, c2, s2, c3, s3,
	input  wire logic [2:0]                       ord,
	output e2q_pkg::quat_t                        quat_q
);
	localparam int PW = 2 * e2q_pkg::XY_W;
	localparam int SW = e2q_pkg::XY_W + 1;
	localparam int SH = 31 - e2q_pkg::COMP_W;

	typedef logic signed [e2q_pkg::XY_W-1:0] v_t;

	v_t s1c2_s1, c1s2_s1, c1c2_s1, s1s2_s1, c3_s1, s3_s1;
	logic [2:0] ord_s1, ord_s2;
	v_t px_s2, qx_s2, py_s2, qy_s2, pz_s2, qz_s2, pw_s2, qw_s2;

	function automatic v_t qmul(input v_t a, input v_t b);
		logic signed [PW-1:0] p;
		p = a * b;
		return p[e2q_pkg::FRAC +: e2q_pkg::XY_W];
	endfunction

	function automatic logic signed [e2q_pkg::COMP_W-1:0] to_comp(
		input v_t p, input v_t q, input logic minus);
		logic signed [SW-1:0] v, r;
		v = minus ? (SW'(p) - SW'(q)) : (SW'(p) + SW'(q));
		r = (v + SW'(1 << (SH - 1))) >>> SH;
		if (r > SW'((1 << (e2q_pkg::COMP_W - 1)) - 1))
			return {1'b0, {(e2q_pkg::COMP_W-1){1'b1}}};
		else if (r < -SW'(1 << (e2q_pkg::COMP_W - 1)))
			return {1'b1, {(e2q_pkg::COMP_W-1){1'b0}}};
		else
			return r[e2q_pkg::COMP_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			s1c2_s1 <= qmul(s1, c2);
			c1s2_s1 <= qmul(c1, s2);
			c1c2_s1 <= qmul(c1, c2);
			s1s2_s1 <= qmul(s1, s2);
			c3_s1   <= c3;
			s3_s1   <= s3;
			ord_s1  <= ord;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2  <= qmul(s1c2_s1, c3_s1);
			qx_s2  <= qmul(c1s2_s1, s3_s1);
			py_s2  <= qmul(c1s2_s1, c3_s1);
			qy_s2  <= qmul(s1c2_s1, s3_s1);
			pz_s2  <= qmul(c1c2_s1, s3_s1);
			qz_s2  <= qmul(s1s2_s1, c3_s1);
			pw_s2  <= qmul(c1c2_s1, c3_s1);
			qw_s2  <= qmul(s1s2_s1, s3_s1);
			ord_s2 <= ord_s1;
		end
	end

	logic [3:0] sg;
	assign sg = e2q_pkg::order_signs(ord_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			if (ord_s2 > e2q_pkg::ORD_XZY) begin
				// identity for unused order codes
				quat_q.quat_x <= '0;
				quat_q.quat_y <= '0;
				quat_q.quat_z <= '0;
				quat_q.quat_w <= {1'b0, {(e2q_pkg::COMP_W-1){1'b1}}};
			end else begin
				quat_q.quat_x <= to_comp(px_s2, qx_s2, sg[3]);
				quat_q.quat_y <= to_comp(py_s2, qy_s2, sg[2]);
				quat_q.quat_z <= to_comp(pz_s2, qz_s2, sg[1]);
				quat_q.quat_w <= to_comp(pw_s2, qw_s2, sg[0]);
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/euler_to_quaternion.sv -----
// Euler angles to unit quaternion. Each transaction is one item through a 31-stage
// pipeline: 28 cordic cells (three angles side by side, one iteration per cell), then
// two multiply stages and a round/saturate stage that is also the output register.
// One item per cycle is sustained while no result waits at the output. The whole pipeline stalls
// only while a result waits at the output. rotation_order is captured with each item.
// top level; depends on e2q_pkg, e2q_cordic_cell and e2q_combine
`default_nettype none
module euler_to_quaternion (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire e2q_pkg::angles_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output e2q_pkg::quat_t         out_data,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_wdata
);
	localparam int N = e2q_pkg::STEPS;
	localparam int DEPTH = N + 3;

	logic adv;
	logic [2:0] rotation_order_q;
	logic [DEPTH-1:0] vld_q;
	logic [2:0] ord_q [N];

	logic signed [e2q_pkg::XY_W-1:0] xs [N+1][3];
	logic signed [e2q_pkg::XY_W-1:0] ys [N+1][3];
	logic signed [e2q_pkg::Z_W-1:0]  zs [N+1][3];
	logic signed [e2q_pkg::ANGLE_W-1:0] ang [3];

	assign adv = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_order_q <= e2q_pkg::ORD_XYZ;
		end else if (cfg_we) begin
			rotation_order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ord_q[0] <= rotation_order_q;
			for (int i = 1; i < N; i++) ord_q[i] <= ord_q[i-1];
		end
	end

	assign ang[0] = in_data.angle_x;
	assign ang[1] = in_data.angle_y;
	assign ang[2] = in_data.angle_z;

	genvar g, a;
	generate
		for (a = 0; a < 3; a++) begin : g_seed
			assign xs[0][a] = e2q_pkg::GAIN;
			assign ys[0][a] = '0;
			// half angle: binary angle scaled so 2^33 is a full turn
			assign zs[0][a] = {{(e2q_pkg::Z_W - e2q_pkg::ANGLE_W - (32 - e2q_pkg::ANGLE_W))
				{ang[a][e2q_pkg::ANGLE_W-1]}}, ang[a], {(32 - e2q_pkg::ANGLE_W){1'b0}}};
		end
		for (g = 0; g < N; g++) begin : g_step
			for (a = 0; a < 3; a++) begin : g_axis
				e2q_cordic_cell #(.STEP(g)) u_cell (
					.clk  (clk),
					.en   (adv),
					.x_in (xs[g][a]),
					.y_in (ys[g][a]),
					.z_in (zs[g][a]),
					.x_q  (xs[g+1][a]),
					.y_q  (ys[g+1][a]),
					.z_q  (zs[g+1][a])
				);
			end
		end
	endgenerate

	e2q_combine u_combine (
		.clk    (clk),
		.en     (adv),
		.c1     (xs[N][0]),
		.s1     (ys[N][0]),
		.c2     (xs[N][1]),
		.s2     (ys[N][1]),
		.c3     (xs[N][2]),
		.s3     (ys[N][2]),
		.ord    (ord_q[N-1]),
		.quat_q (out_data)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");
	a_accept_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction not entered in pipeline");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ----- tb/euler_to_quaternion_tb.sv -----
// testbench for euler_to_quaternion: directed table then random angles, checked
// against a bit-exact cordic predictor; depends on e2q_pkg and the block in src
`timescale 1ns / 1ps
`default_nettype none
module euler_to_quaternion_tb;
	localparam logic [2:0] ORD_IDENT = 3'd6;
	localparam int LATENCY = 31;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	e2q_pkg::angles_t in_data;
	e2q_pkg::quat_t out_data;
	logic [2:0] cfg_wdata;

	logic [2:0] order_reg;
	e2q_pkg::quat_t quat_expected[$];
	int errors = 0;
	bit tail_quiet = 0;

	euler_to_quaternion uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("euler_to_quaternion: mismatch");
		$finish;
	end

	function automatic longint fdiv(longint v, int s);
		return v >>> s;
	endfunction

	// rotation-mode cordic on the half angle, returns cos and sin in q30
	function automatic void half_cos_sin(logic signed [15:0] ang, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'(ang) * 65536;
		for (int i = 0; i < e2q_pkg::STEPS; i++) begin
			dx = fdiv(y, i);
			dy = fdiv(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= 2 * longint'(e2q_pkg::atan_step(i));
			end else begin
				x += dx; y -= dy; z += 2 * longint'(e2q_pkg::atan_step(i));
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint prod3(longint a, longint b, longint c);
		return fdiv(fdiv(a * b, 30) * c, 30);
	endfunction

	function automatic logic [15:0] round_sat(longint v);
		longint r;
		r = fdiv(v + (1 << 14), 15);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic e2q_pkg::quat_t predict_quat(e2q_pkg::angles_t a, logic [2:0] ord);
		e2q_pkg::quat_t q;
		longint c1, s1, c2, s2, c3, s3;
		logic [3:0] sg;
		q = '0;
		case (ord)
			e2q_pkg::ORD_XYZ: sg = 4'h5;
			e2q_pkg::ORD_YXZ: sg = 4'h6;
			e2q_pkg::ORD_ZXY: sg = 4'h9;
			e2q_pkg::ORD_ZYX: sg = 4'hA;
			e2q_pkg::ORD_YZX: sg = 4'h3;
			e2q_pkg::ORD_XZY: sg = 4'hC;
			default: begin
				q.quat_w = 16'sd32767;
				return q;
			end
		endcase
		half_cos_sin(a.angle_x, c1, s1);
		half_cos_sin(a.angle_y, c2, s2);
		half_cos_sin(a.angle_z, c3, s3);
		q.quat_x = round_sat(sg[3] ? prod3(s1, c2, c3) - prod3(c1, s2, s3)
			: prod3(s1, c2, c3) + prod3(c1, s2, s3));
		q.quat_y = round_sat(sg[2] ? prod3(c1, s2, c3) - prod3(s1, c2, s3)
			: prod3(c1, s2, c3) + prod3(s1, c2, s3));
		q.quat_z = round_sat(sg[1] ? prod3(c1, c2, s3) - prod3(s1, s2, c3)
			: prod3(c1, c2, s3) + prod3(s1, s2, c3));
		q.quat_w = round_sat(sg[0] ? prod3(c1, c2, c3) - prod3(s1, s2, s3)
			: prod3(c1, c2, c3) + prod3(s1, s2, s3));
		return q;
	endfunction

	// receiver: random stall bursts, checks each transaction at the rising edge
	initial begin
		int stall;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ready = 0;
			end else if (!tail_quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 3);
				out_ready = 0;
			end else
				out_ready = 1;
		end
	end

	always @(posedge clk) begin
		e2q_pkg::quat_t exp_q;
		if (arst_n && out_valid && out_ready) begin
			if (quat_expected.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, out_data);
			end else begin
				exp_q = quat_expected.pop_front();
				if (exp_q.quat_x !== out_data.quat_x || exp_q.quat_y !== out_data.quat_y ||
						exp_q.quat_z !== out_data.quat_z || exp_q.quat_w !== out_data.quat_w) begin
					errors++;
					$display("%0t expected %h actual %h", $time, exp_q, out_data);
				end
			end
		end
	end

	task automatic write_order(logic [2:0] ord);
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = ord;
		@(negedge clk);
		cfg_we = 0;
		order_reg = ord;
	endtask

	task automatic drain();
		while (quat_expected.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// one transaction; expectation is queued when accepted
	task automatic send_angles(e2q_pkg::angles_t a, e2q_pkg::quat_t q);
		if (!tail_quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		in_data = a;
		do @(posedge clk); while (!in_ready);
		quat_expected.push_back(q);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(signed'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	typedef struct {
		logic [15:0] ax, ay, az;
		bit known;
		e2q_pkg::quat_t q;
	} stim_row_t;

	stim_row_t dir_rows[] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1, '{16'h0, 16'h0, 16'h0, 16'h7fff}},
		'{16'h8000, 16'h0000, 16'h0000, 0, '0},
		'{16'h7fff, 16'h0000, 16'h0000, 0, '0},
		'{16'h0000, 16'h8000, 16'h0000, 0, '0},
		'{16'h0000, 16'h7fff, 16'h0000, 0, '0},
		'{16'h0000, 16'h0000, 16'h8000, 0, '0},
		'{16'h0000, 16'h0000, 16'h7fff, 0, '0},
		'{16'h8000, 16'h8000, 16'h8000, 0, '0},
		'{16'h7fff, 16'h7fff, 16'h7fff, 0, '0},
		'{16'hffff, 16'h0001, 16'hffff, 0, '0},
		'{16'h4000, 16'hc000, 16'h2000, 0, '0},
		'{16'h5555, 16'haaaa, 16'h1234, 0, '0}
	};

	initial begin
		e2q_pkg::angles_t a;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		order_reg = e2q_pkg::ORD_XYZ;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset order first, then every order incl. both identity codes
		for (int ord = 0; ord < 9; ord++) begin
			if (ord > 0) begin
				drain();
				write_order(3'(ord - 1));
			end
			foreach (dir_rows[i]) begin
				a = '{dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az};
				send_angles(a, (dir_rows[i].known && ord == 0) ? dir_rows[i].q
					: predict_quat(a, order_reg));
			end
		end

		for (int n = 0; n < 1250; n++) begin
			if (n % 150 == 149) begin
				// pause until all results are back, then maybe change order
				drain();
				if ($urandom_range(0, 1)) write_order($urandom_range(0, 7) == 7 ? ORD_IDENT
					: 3'($urandom_range(0, 5)));
			end
			if (n == 1100) tail_quiet = 1;
			a = '{rand_angle(), rand_angle(), rand_angle()};
			send_angles(a, predict_quat(a, order_reg));
		end
		drain();
		if (errors == 0)
			$display("euler_to_quaternion: match");
		else
			$display("euler_to_quaternion: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
